>>> hw/rtl/orb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwriting ring buffer package
// Shared widths, operation and status codes and the result metadata type.
// ----------------------------------------------------------------------------
package orb_pkg;

   // Fixed field widths
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int CAP_W  = 7;

   // Built ring depth and capacity register reset
   localparam int DEPTH_DEFAULT = 64;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef logic [OP_W-1:0]   op_type;
   typedef logic [STAT_W-1:0] stat_type;

   // Operation codes
   localparam op_type OP_PUSH  = 2'd0;
   localparam op_type OP_POP   = 2'd1;
   localparam op_type OP_PEEK  = 2'd2;
   localparam op_type OP_CLEAR = 2'd3;

   // Status codes
   localparam stat_type STAT_OK    = 2'd0;
   localparam stat_type STAT_OVWR  = 2'd1;
   localparam stat_type STAT_EMPTY = 2'd2;

   // Result metadata held next to the RAM read data
   typedef struct packed {
      stat_type         status;
      logic [CAP_W-1:0] count;
      logic             is_full;
      logic             rd_sel;
   } orb_meta_type;

endpackage

>>> hw/rtl/orb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwriting ring buffer channels
// Request and response channels with a valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface orb_req_if;
   import orb_pkg::*;

   logic              valid;
   logic              ready;
   op_type            opcode;
   logic [DATA_W-1:0] data_in;

   modport source (output valid, output opcode, output data_in, input ready);
   modport sink   (input valid, input opcode, input data_in, output ready);
endinterface

interface orb_rsp_if;
   import orb_pkg::*;

   logic              valid;
   logic              ready;
   stat_type          status;
   logic [DATA_W-1:0] read_data;
   logic [CAP_W-1:0]  count;
   logic              is_full;

   modport source (output valid, output status, output read_data, output count,
                   output is_full, input ready);
   modport sink   (input valid, input status, input read_data, input count,
                   input is_full, output ready);
endinterface

>>> hw/rtl/orb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module orb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/orb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwriting ring buffer control
// Pointer and full-flag update, RAM access control and the result register.
// ----------------------------------------------------------------------------
module orb_ctrl #(
   parameter int DEPTH = orb_pkg::DEPTH_DEFAULT,
   parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  orb_pkg::op_type           opcode,
   input  logic [orb_pkg::CAP_W-1:0] capacity,
   input  logic                      rsp_take,
   output logic                      rsp_valid,
   output orb_pkg::orb_meta_type     meta,
   output logic                      wr_en,
   output logic [PTR_W-1:0]          wr_addr,
   output logic                      rd_en,
   output logic [PTR_W-1:0]          rd_addr
);
   import orb_pkg::*;

   localparam int CMP_W = ((PTR_W + 1) > CAP_W) ? (PTR_W + 1) : CAP_W;
   localparam int SW    = CMP_W + 2;

   logic [PTR_W-1:0] write_pos_ff, write_pos_in;
   logic [PTR_W-1:0] read_pos_ff, read_pos_in;
   logic             full_ff, full_in;
   logic             rsp_valid_ff, rsp_valid_in;
   orb_meta_type     meta_ff, meta_in;
   stat_type         stat_in;
   logic             rd_sel_in;
   logic [CAP_W-1:0] count_in;
   logic [CAP_W-1:0] cap_use;
   logic             empty;
   logic signed [SW-1:0] cnt_diff;
   logic signed [SW-1:0] cnt_raw;
   logic signed [SW-1:0] cap_s;

   // Step a position, wrap at the capacity in use
   function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                            input logic [CAP_W-1:0] c);
      logic [CMP_W-1:0] nx;
      nx = CMP_W'(p) + CMP_W'(1);
      return (nx >= CMP_W'(c)) ? '0 : PTR_W'(nx);
   endfunction

   // Clamp the capacity register to 1..DEPTH
   always_comb begin
      if (capacity == '0) begin
         cap_use = CAP_W'(1);
      end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
         cap_use = CAP_W'(DEPTH);
      end else begin
         cap_use = capacity;
      end
   end

   assign empty = !full_ff && (write_pos_ff == read_pos_ff);

   // Next pointers, flag and status for the accepted operation
   always_comb begin
      write_pos_in = write_pos_ff;
      read_pos_in  = read_pos_ff;
      full_in      = full_ff;
      stat_in      = STAT_OK;
      rd_sel_in    = 1'b0;
      if (accept) begin
         unique case (opcode)
            OP_PUSH: begin
               if (full_ff) begin
                  read_pos_in = adv(read_pos_ff, cap_use);
                  stat_in     = STAT_OVWR;
               end
               write_pos_in = adv(write_pos_ff, cap_use);
               full_in      = (write_pos_in == read_pos_in);
            end
            OP_POP, OP_PEEK: begin
               if (empty) begin
                  stat_in = STAT_EMPTY;
               end else begin
                  rd_sel_in = 1'b1;
                  if (opcode == OP_POP) begin
                     full_in     = 1'b0;
                     read_pos_in = adv(read_pos_ff, cap_use);
                  end
               end
            end
            OP_CLEAR: begin
               write_pos_in = '0;
               read_pos_in  = '0;
               full_in      = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   // Element count after the operation, held within 0..capacity
   assign cap_s    = SW'(cap_use);
   assign cnt_diff = SW'(write_pos_in) - SW'(read_pos_in);
   assign cnt_raw  = (write_pos_in >= read_pos_in) ? cnt_diff : (cap_s + cnt_diff);

   always_comb begin
      if (full_in) begin
         count_in = cap_use;
      end else if (cnt_raw < 0) begin
         count_in = '0;
      end else if (cnt_raw > cap_s) begin
         count_in = cap_use;
      end else begin
         count_in = cnt_raw[CAP_W-1:0];
      end
   end

   // Gather the result metadata
   assign meta_in = '{status: stat_in, count: count_in, is_full: full_in,
                      rd_sel: rd_sel_in};

   // Hold the result until the transfer, refill on acceptance
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff <= '0;
         read_pos_ff  <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         write_pos_ff <= write_pos_in;
         read_pos_ff  <= read_pos_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta_in;
      end
   end

   // RAM access: push writes at the head, every transfer reads the oldest
   assign wr_en     = accept && (opcode == OP_PUSH);
   assign wr_addr   = write_pos_ff;
   assign rd_en     = accept;
   assign rd_addr   = read_pos_ff;
   assign rsp_valid = rsp_valid_ff;
   assign meta      = meta_ff;

   // A set full flag always has the pointers meeting
   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (write_pos_ff == read_pos_ff))
      else $error("full flag set with pointers apart");

   // An overwriting push leaves the ring full
   a_ovwr_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && meta_ff.status == STAT_OVWR) |-> meta_ff.is_full)
      else $error("overwrite reported without full ring");

   // An empty error selects no read word and reports no words
   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && meta_ff.status == STAT_EMPTY)
         |-> (meta_ff.count == '0 && !meta_ff.rd_sel && !meta_ff.is_full))
      else $error("empty error with stored words");

endmodule

>>> hw/rtl/overwriting_ring_buffer.sv
`timescale 1ns / 1ps
// A result is valid in the cycle after its request transfer. Throughput:
// one operation per cycle while results are taken; the registered RAM read
// of the oldest word, issued at the request transfer, is the result.
// Reset: pointers and full flag clear, capacity returns to 64 and any pending
// result is dropped; ring contents are not cleared.
// ----------------------------------------------------------------------------
// Overwriting ring buffer
// Ring of 32-bit words with push, pop, peek and clear; push overwrites the
// oldest word when full.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer #(
   parameter int DEPTH = orb_pkg::DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   orb_req_if.sink                   req_ch,
   orb_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [orb_pkg::CAP_W-1:0] csr_wr_data
);
   import orb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CAP_W-1:0]  capacity_ff;
   logic              accept;
   logic              rsp_take;
   logic              rsp_valid;
   orb_meta_type      meta;
   logic              wr_en;
   logic [PTR_W-1:0]  wr_addr;
   logic              rd_en;
   logic [PTR_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // Take a request whenever the result slot is free or draining
   assign rsp_take     = rsp_valid && rsp_ch.ready;
   assign req_ch.ready = !rsp_valid || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   orb_ctrl #(
      .DEPTH (DEPTH),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .opcode    (req_ch.opcode),
      .capacity  (capacity_ff),
      .rsp_take  (rsp_take),
      .rsp_valid (rsp_valid),
      .meta      (meta),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr)
   );

   orb_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH),
      .AW    (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ch.data_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Drive the response; zero the word unless a pop or peek succeeded
   assign rsp_ch.valid     = rsp_valid;
   assign rsp_ch.status    = meta.status;
   assign rsp_ch.read_data = meta.rd_sel ? rd_data : '0;
   assign rsp_ch.count     = meta.count;
   assign rsp_ch.is_full   = meta.is_full;

endmodule

>>> sim/tb_overwriting_ring_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Overwriting ring buffer testbench
// Drives push, pop, peek and clear requests through the request channel,
// tracks the ring in a local shadow and compares every reply field by field.
// Capacity is rewritten between phases, with and without a following clear.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_buffer;
   import orb_pkg::*;

   localparam int RING_DEPTH = DEPTH_DEFAULT;
   localparam int MAX_SHOWN  = 10;

   typedef struct {
      stat_type          status;
      logic [DATA_W-1:0] read_data;
      logic [CAP_W-1:0]  count;
      logic              is_full;
   } ring_reply_type;

   // Shadow of the ring plus the queue of replies it predicts
   class ring_tracker_type;
      logic [DATA_W-1:0] words [RING_DEPTH];
      bit                written [RING_DEPTH];
      int                wr_pos;
      int                rd_pos;
      bit                full;
      logic [CAP_W-1:0]  cap_reg;
      ring_reply_type    pending_replies [$];
      int faults, checked;
      int pushes, pops, peeks, clears, overwrites, empties, cap_writes;

      function new();
         wr_pos  = 0;
         rd_pos  = 0;
         full    = 1'b0;
         cap_reg = CAP_RESET;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      // Zero acts as one, anything above the built depth as the depth
      function int usable_cap();
         if (cap_reg == 0) return 1;
         if (cap_reg > RING_DEPTH) return RING_DEPTH;
         return int'(cap_reg);
      endfunction

      function int step_pos(int pos, int cap);
         return (pos + 1 >= cap) ? 0 : pos + 1;
      endfunction

      function bit is_empty();
         return !full && (wr_pos == rd_pos);
      endfunction

      // Pop or peek may only land on an entry that was written at some point
      function bit read_is_safe();
         return is_empty() || written[rd_pos];
      endfunction

      function int stored_count(int cap);
         int n;
         if (full) return cap;
         n = (wr_pos >= rd_pos) ? wr_pos - rd_pos : cap + wr_pos - rd_pos;
         if (n < 0) n = 0;
         if (n > cap) n = cap;
         return n;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         cap_reg = value;
         cap_writes++;
      endfunction

      // Advance the shadow by one accepted request and queue its reply
      function void apply_op(op_type op, logic [DATA_W-1:0] word);
         ring_reply_type r;
         int cap;
         cap         = usable_cap();
         r.status    = STAT_OK;
         r.read_data = '0;
         case (op)
            OP_PUSH: begin
               words[wr_pos]   = word;
               written[wr_pos] = 1'b1;
               if (full) begin
                  rd_pos   = step_pos(rd_pos, cap);
                  r.status = STAT_OVWR;
                  overwrites++;
               end
               wr_pos = step_pos(wr_pos, cap);
               full   = (wr_pos == rd_pos);
               pushes++;
            end
            OP_POP, OP_PEEK: begin
               if (is_empty()) begin
                  r.status = STAT_EMPTY;
                  empties++;
               end else begin
                  r.read_data = words[rd_pos];
                  if (op == OP_POP) begin
                     full   = 1'b0;
                     rd_pos = step_pos(rd_pos, cap);
                  end
               end
               if (op == OP_POP) pops++;
               else peeks++;
            end
            default: begin
               wr_pos = 0;
               rd_pos = 0;
               full   = 1'b0;
               clears++;
            end
         endcase
         r.count   = CAP_W'(stored_count(cap));
         r.is_full = full;
         pending_replies.push_back(r);
      endfunction

      // Compare one reply transfer against the oldest prediction
      function void check_reply(ring_reply_type got);
         ring_reply_type want;
         if (pending_replies.size() == 0) begin
            faults++;
            if (faults <= MAX_SHOWN)
               $display("unexpected reply: status %0d data %h count %0d full %0d",
                        got.status, got.read_data, got.count, got.is_full);
            return;
         end
         want = pending_replies.pop_front();
         if (got.status !== want.status || got.read_data !== want.read_data ||
             got.count !== want.count || got.is_full !== want.is_full) begin
            faults++;
            if (faults <= MAX_SHOWN) begin
               $display("reply %0d mismatch: expected st %0d data %h cnt %0d full %0d",
                        checked, want.status, want.read_data, want.count, want.is_full);
               $display("   got st %0d data %h cnt %0d full %0d",
                        got.status, got.read_data, got.count, got.is_full);
            end
         end
         checked++;
      endfunction

      function void close_out();
         if (pending_replies.size() != 0) begin
            faults += pending_replies.size();
            $display("%0d predicted replies never arrived", pending_replies.size());
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   orb_req_if req ();
   orb_rsp_if rsp ();

   ring_tracker_type board;
   int req_idle_pct;
   int rsp_idle_pct;

   overwriting_ring_buffer dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Sample reply transfers and randomly hold off ready
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            board.check_reply('{rsp.status, rsp.read_data, rsp.count, rsp.is_full});
         rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Present one request, idling first at random, and record it at its transfer
   task automatic send_op(op_type op, logic [DATA_W-1:0] word);
      while ($urandom_range(99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.opcode  <= op;
      req.data_in <= word;
      do @(posedge clock); while (req.ready !== 1'b1);
      board.apply_op(op, word);
   endtask

   // Drop valid and hold until every predicted reply has come back
   task automatic drain();
      req.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_capacity(value);
   endtask

   // Bursts that lean toward filling, toward draining, or mixed
   task automatic random_ops(int total);
      int left, burst, push_pct, pop_pct, roll;
      op_type op;
      left = total;
      while (left > 0) begin
         burst = $urandom_range(60, 4);
         case ($urandom_range(2))
            0: begin
               push_pct = 85;
               pop_pct  = 8;
            end
            1: begin
               push_pct = 15;
               pop_pct  = 65;
            end
            default: begin
               push_pct = 45;
               pop_pct  = 30;
            end
         endcase
         for (int i = 0; i < burst && left > 0; i++) begin
            roll = $urandom_range(99);
            if (roll < push_pct) op = OP_PUSH;
            else if (roll < push_pct + pop_pct) op = OP_POP;
            else if (roll < 97) op = OP_PEEK;
            else op = OP_CLEAR;
            // never read an entry that was not written yet
            if ((op == OP_POP || op == OP_PEEK) && !board.read_is_safe()) op = OP_PUSH;
            send_op(op, $urandom());
            left--;
         end
      end
   endtask

   initial begin
      logic [CAP_W-1:0] phase_caps [10];
      phase_caps   = '{7'd1, 7'd2, 7'd5, 7'd64, 7'd17, 7'd0, 7'd127, 7'd8, 7'd63, 7'd3};
      board        = new();
      req_idle_pct = 24;
      rsp_idle_pct = 47;
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.opcode  <= OP_PUSH;
      req.data_in <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= CAP_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty errors, extreme words, full drain at reset capacity
      send_op(OP_POP, 32'h1234_5678);
      send_op(OP_PEEK, 32'hFFFF_FFFF);
      send_op(OP_PUSH, 32'h0000_0000);
      send_op(OP_PUSH, 32'hFFFF_FFFF);
      send_op(OP_PEEK, 32'h0);
      send_op(OP_POP, 32'h0);
      send_op(OP_POP, 32'h0);
      send_op(OP_POP, 32'h0);

      // Single entry ring: second push overwrites
      write_capacity(7'd1);
      send_op(OP_CLEAR, 32'hDEAD_BEEF);
      send_op(OP_PUSH, 32'hA5A5_A5A5);
      send_op(OP_PUSH, 32'h5A5A_5A5A);
      send_op(OP_POP, 32'h0);
      send_op(OP_PEEK, 32'h0);

      // Wrap a three entry ring, then shrink it without a clear
      write_capacity(7'd3);
      send_op(OP_CLEAR, 32'h0);
      for (int i = 0; i < 4; i++) send_op(OP_PUSH, 32'h8000_0001 + i);
      send_op(OP_POP, 32'h0);
      write_capacity(7'd2);
      send_op(OP_POP, 32'h0);
      send_op(OP_PUSH, 32'h0F0F_0F0F);

      // Out of range capacity values
      write_capacity(7'd0);
      send_op(OP_CLEAR, 32'h0);
      send_op(OP_PUSH, 32'h1111_1111);
      send_op(OP_PUSH, 32'h2222_2222);
      write_capacity(7'd127);
      send_op(OP_CLEAR, 32'h0);
      send_op(OP_PUSH, 32'h3333_3333);
      send_op(OP_POP, 32'h0);

      // Random phases; odd phases keep the old pointers across the capacity change
      foreach (phase_caps[p]) begin
         write_capacity(phase_caps[p]);
         if (p < 4) begin
            req_idle_pct = 24;
            rsp_idle_pct = 47;
         end else if (p < 7) begin
            req_idle_pct = 47;
            rsp_idle_pct = 24;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         if (p % 2 == 0) send_op(OP_CLEAR, $urandom());
         random_ops(170);
      end

      drain();
      board.close_out();
      $display("Ran %0d requests: %0d push, %0d pop, %0d peek, %0d clear; %0d replies checked",
               board.pushes + board.pops + board.peeks + board.clears, board.pushes,
               board.pops, board.peeks, board.clears, board.checked);
      $display("Saw %0d overwrites and %0d empty errors over %0d capacity writes",
               board.overwrites, board.empties, board.cap_writes);
      if (board.faults == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
